[sv/tsq_pkg.sv]
package tsq_pkg;

  // digit width of one partial-product cell in the multiplier chains
  localparam int DIGIT_BITS = 16;

  // flags that ride along the divider and square-root chains
  typedef struct packed {
    logic deg;  // zero volume
    logic sat;  // ratio at or above one
  } tsq_flags_t;

endpackage

[sv/tetrahedron_shape_quality_unit.sv]
// Tetrahedron shape quality: sqrt(2) * 6V / emax^3, in unsigned Q1.F.
// Input channel in_*: one item carries the twelve corner coordinates
// ax..dz, each COORD_BITS two's complement, packed lowest first.
// Output channel out_*: quality (F+1 bits, 2^F means 1.0, saturated) in
// out_tdata and the degenerate flag (zero volume, quality 0) in out_tuser.
// One item per cycle is accepted and delivered in steady state while out_tready is high.
// An item passes the difference, product and max stages, three
// multiplier cell chains (T^2, E^2, E^3) with one cell per 16-bit digit
// of |triple product| and of the squared edge, one saturation compare,
// a 2F-cell restoring divider and an F-cell square-root chain.
// All stages move together: when out_tvalid is high and out_tready is low
// the whole chain holds and in_tready drops; the result register keeps
// its item until taken. Synchronous reset empties the chain; no item is
// lost or duplicated across a stall.
module tetrahedron_shape_quality_unit import tsq_pkg::*; #(
  parameter int COORD_BITS        = 16,
  parameter int QUALITY_FRAC_BITS = 16
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        in_tvalid,
  output logic                                        in_tready,
  // ax, ay, az, bx, by, bz, cx, cy, cz, dx, dy, dz (COORD_BITS each)
  input  logic [((12*COORD_BITS+7)/8)*8-1:0]          in_tdata,
  output logic                                        out_tvalid,
  input  logic                                        out_tready,
  // quality (QUALITY_FRAC_BITS+1 bits)
  output logic [((QUALITY_FRAC_BITS+1+7)/8)*8-1:0]    out_tdata,
  // degenerate
  output logic                                        out_tuser
);

  localparam int CB  = COORD_BITS;
  localparam int F   = QUALITY_FRAC_BITS;
  localparam int DW  = CB + 1;        // corner difference
  localparam int EDW = CB + 1;        // any edge difference
  localparam int PW  = 2 * DW;        // cross-product term
  localparam int CRW = PW + 1;        // cross-product component
  localparam int TPW = DW + CRW;      // triple-product term
  localparam int TW  = TPW + 2;       // triple product
  localparam int SQW = 2 * EDW;       // squared coordinate difference
  localparam int EW  = SQW + 2;       // squared edge length
  localparam int RW  = 3 * EW;        // E^3 and divider remainder
  localparam int QW  = 2 * F;         // quotient feeding the root
  localparam int OW  = F + 1;
  localparam int OBW = ((F + 1 + 7) / 8) * 8;

  logic en;
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  // ---------------------------------------------------------------- stage 1
  logic signed [CB-1:0] crd [12];
  for (genvar i = 0; i < 12; i++) begin : g_crd
    assign crd[i] = in_tdata[i*CB +: CB];
  end

  logic                  s1_v_r;
  logic signed [EDW-1:0] s1_d_r [6][3];   // AB, AC, AD, BC, BD, CD
  logic signed [EDW-1:0] s1_d_nxt [6][3];

  // coordinate differences for every edge: AB, AC, AD, BC, BD, CD
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      s1_d_nxt[0][k] = EDW'(crd[3+k])  - EDW'(crd[k]);
      s1_d_nxt[1][k] = EDW'(crd[6+k])  - EDW'(crd[k]);
      s1_d_nxt[2][k] = EDW'(crd[9+k])  - EDW'(crd[k]);
      s1_d_nxt[3][k] = EDW'(crd[6+k])  - EDW'(crd[3+k]);
      s1_d_nxt[4][k] = EDW'(crd[9+k])  - EDW'(crd[3+k]);
      s1_d_nxt[5][k] = EDW'(crd[9+k])  - EDW'(crd[6+k]);
    end
  end

  // ---------------------------------------------------------------- stage 2
  logic                  s2_v_r;
  logic signed [PW-1:0]  s2_p_r [6], s2_p_nxt [6];
  logic signed [SQW-1:0] s2_sq_r [6][3], s2_sq_nxt [6][3];
  logic signed [DW-1:0]  s2_u_r [3];

  // cross-product terms of AC x AD and squared differences
  always_comb begin
    s2_p_nxt[0] = s1_d_r[1][1] * s1_d_r[2][2];
    s2_p_nxt[1] = s1_d_r[1][2] * s1_d_r[2][1];
    s2_p_nxt[2] = s1_d_r[1][2] * s1_d_r[2][0];
    s2_p_nxt[3] = s1_d_r[1][0] * s1_d_r[2][2];
    s2_p_nxt[4] = s1_d_r[1][0] * s1_d_r[2][1];
    s2_p_nxt[5] = s1_d_r[1][1] * s1_d_r[2][0];
    for (int j = 0; j < 6; j++) begin
      for (int k = 0; k < 3; k++) begin
        s2_sq_nxt[j][k] = s1_d_r[j][k] * s1_d_r[j][k];
      end
    end
  end

  // ---------------------------------------------------------------- stage 3
  logic                  s3_v_r;
  logic signed [CRW-1:0] s3_cr_r [3], s3_cr_nxt [3];
  logic [EW-1:0]         s3_len_r [6], s3_len_nxt [6];
  logic signed [DW-1:0]  s3_u_r [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      s3_cr_nxt[k] = CRW'(s2_p_r[2*k]) - CRW'(s2_p_r[2*k+1]);
    end
    for (int j = 0; j < 6; j++) begin
      s3_len_nxt[j] = EW'(unsigned'(s2_sq_r[j][0])) + EW'(unsigned'(s2_sq_r[j][1]))
                    + EW'(unsigned'(s2_sq_r[j][2]));
    end
  end

  // ---------------------------------------------------------------- stage 4
  logic                  s4_v_r;
  logic signed [TPW-1:0] s4_tp_r [3], s4_tp_nxt [3];
  logic [EW-1:0]         s4_m_r [3], s4_m_nxt [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      s4_tp_nxt[k] = s3_u_r[k] * s3_cr_r[k];
      s4_m_nxt[k]  = (s3_len_r[2*k] > s3_len_r[2*k+1]) ? s3_len_r[2*k] : s3_len_r[2*k+1];
    end
  end

  // ---------------------------------------------------------------- stage 5
  logic                 s5_v_r;
  logic [TW-1:0]        s5_t_r, s5_t_nxt;
  logic [EW-1:0]        s5_e_r, s5_e_nxt, m01;
  logic                 s5_deg_r, s5_deg_nxt;
  logic signed [TW-1:0] trip;

  // absolute triple product and longest squared edge
  always_comb begin
    trip       = TW'(s4_tp_r[0]) + TW'(s4_tp_r[1]) + TW'(s4_tp_r[2]);
    s5_t_nxt   = trip[TW-1] ? TW'(-trip) : TW'(trip);
    s5_deg_nxt = (trip == '0);
    m01        = (s4_m_r[0] > s4_m_r[1]) ? s4_m_r[0] : s4_m_r[1];
    s5_e_nxt   = (m01 > s4_m_r[2]) ? m01 : s4_m_r[2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
      s5_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_tvalid;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
      s5_v_r <= s4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_d_r   <= s1_d_nxt;
      s2_p_r   <= s2_p_nxt;
      s2_sq_r  <= s2_sq_nxt;
      for (int k = 0; k < 3; k++) begin
        s2_u_r[k] <= DW'(s1_d_r[0][k]);
      end
      s3_cr_r  <= s3_cr_nxt;
      s3_len_r <= s3_len_nxt;
      s3_u_r   <= s2_u_r;
      s4_tp_r  <= s4_tp_nxt;
      s4_m_r   <= s4_m_nxt;
      s5_t_r   <= s5_t_nxt;
      s5_e_r   <= s5_e_nxt;
      s5_deg_r <= s5_deg_nxt;
    end
  end

  // ------------------------------------------------------- multiplier chains
  logic              m1_v, m2_v, m3_v;
  logic [2*TW-1:0]   m1_t2, m2_t2, m3_t2;
  logic [EW-1:0]     m1_e, m2_e;
  logic              m1_deg, m2_deg, m3_deg;
  logic [2*EW-1:0]   m2_e2;
  logic [3*EW-1:0]   m3_e3;

  tsq_mul #(.WA(TW), .WB(TW), .WS(EW+1)) u_mul_t2 (
    .clk, .rst_n, .en,
    .v_i(s5_v_r), .a_i(s5_t_r), .b_i(s5_t_r), .side_i({s5_e_r, s5_deg_r}),
    .v_o(m1_v), .p_o(m1_t2), .side_o({m1_e, m1_deg})
  );

  tsq_mul #(.WA(EW), .WB(EW), .WS(2*TW+EW+1)) u_mul_e2 (
    .clk, .rst_n, .en,
    .v_i(m1_v), .a_i(m1_e), .b_i(m1_e), .side_i({m1_t2, m1_e, m1_deg}),
    .v_o(m2_v), .p_o(m2_e2), .side_o({m2_t2, m2_e, m2_deg})
  );

  tsq_mul #(.WA(2*EW), .WB(EW), .WS(2*TW+1)) u_mul_e3 (
    .clk, .rst_n, .en,
    .v_i(m2_v), .a_i(m2_e2), .b_i(m2_e), .side_i({m2_t2, m2_deg}),
    .v_o(m3_v), .p_o(m3_e3), .side_o({m3_t2, m3_deg})
  );

  // ---------------------------------------------------- saturation compare
  logic          sc_v_r;
  logic [RW-1:0] sc_rem_r, sc_rem_nxt, sc_e3_r;
  tsq_flags_t    sc_f_r, sc_f_nxt;

  // quality reaches one exactly when 2 * T^2 >= E^3
  always_comb begin
    sc_rem_nxt   = RW'({m3_t2, 1'b0});
    sc_f_nxt.sat = (sc_rem_nxt >= m3_e3);
    sc_f_nxt.deg = m3_deg;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sc_v_r <= 1'b0;
    end else if (en) begin
      sc_v_r <= m3_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sc_rem_r <= sc_rem_nxt;
      sc_e3_r  <= m3_e3;
      sc_f_r   <= sc_f_nxt;
    end
  end

  // ------------------------------------------------------------ divider chain
  logic          dv_v   [QW+1];
  logic [RW-1:0] dv_rem [QW+1];
  logic [RW-1:0] dv_dvs [QW+1];
  logic [QW-1:0] dv_q   [QW+1];
  tsq_flags_t    dv_f   [QW+1];

  assign dv_v[0]   = sc_v_r;
  assign dv_rem[0] = sc_rem_r;
  assign dv_dvs[0] = sc_e3_r;
  assign dv_q[0]   = '0;
  assign dv_f[0]   = sc_f_r;

  for (genvar k = 0; k < QW; k++) begin : g_div
    tsq_div_cell #(.RW(RW), .QW(QW)) u_cell (
      .clk, .rst_n, .en,
      .v_i(dv_v[k]), .rem_i(dv_rem[k]), .dvs_i(dv_dvs[k]), .q_i(dv_q[k]), .f_i(dv_f[k]),
      .v_o(dv_v[k+1]), .rem_o(dv_rem[k+1]), .dvs_o(dv_dvs[k+1]), .q_o(dv_q[k+1]),
      .f_o(dv_f[k+1])
    );
  end

  // ------------------------------------------------------ square-root chain
  logic           sq_v    [F+1];
  logic [QW-1:0]  sq_x    [F+1];
  logic [F+2:0]   sq_rem  [F+1];
  logic [F-1:0]   sq_root [F+1];
  tsq_flags_t     sq_f    [F+1];

  assign sq_v[0]    = dv_v[QW];
  assign sq_x[0]    = dv_q[QW];
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_f[0]    = dv_f[QW];

  for (genvar k = 0; k < F; k++) begin : g_sqrt
    tsq_sqrt_cell #(.F(F)) u_cell (
      .clk, .rst_n, .en,
      .v_i(sq_v[k]), .x_i(sq_x[k]), .rem_i(sq_rem[k]), .root_i(sq_root[k]), .f_i(sq_f[k]),
      .v_o(sq_v[k+1]), .x_o(sq_x[k+1]), .rem_o(sq_rem[k+1]), .root_o(sq_root[k+1]),
      .f_o(sq_f[k+1])
    );
  end

  // ------------------------------------------------------------------ output
  logic [OW-1:0] quality;

  always_comb begin
    priority if (sq_f[F].deg) begin
      quality = '0;
    end else if (sq_f[F].sat) begin
      quality = OW'(1) << F;
    end else begin
      quality = {1'b0, sq_root[F]};
    end
  end

  assign out_tvalid = sq_v[F];
  assign out_tdata  = OBW'(quality);
  assign out_tuser  = sq_f[F].deg;

endmodule

[sv/tsq_mul.sv]
// Unsigned multiplier as a chain of partial-product cells: each cell adds
// a times one digit of b to the running sum and hands everything on.
module tsq_mul import tsq_pkg::*; #(
  parameter int WA = 54,
  parameter int WB = 54,
  parameter int WS = 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             v_i,
  input  logic [WA-1:0]    a_i,
  input  logic [WB-1:0]    b_i,
  input  logic [WS-1:0]    side_i,
  output logic             v_o,
  output logic [WA+WB-1:0] p_o,
  output logic [WS-1:0]    side_o
);

  localparam int NS = (WB + DIGIT_BITS - 1) / DIGIT_BITS;
  localparam int BP = NS * DIGIT_BITS;
  localparam int AW = WA + BP;

  logic          v_w    [NS+1];
  logic [WA-1:0] a_w    [NS+1];
  logic [BP-1:0] b_w    [NS+1];
  logic [WS-1:0] side_w [NS+1];
  logic [AW-1:0] acc_w  [NS+1];

  assign v_w[0]    = v_i;
  assign a_w[0]    = a_i;
  assign b_w[0]    = BP'(b_i);
  assign side_w[0] = side_i;
  assign acc_w[0]  = '0;

  for (genvar k = 0; k < NS; k++) begin : g_cell
    logic                       v_r;
    logic [WA-1:0]              a_r;
    logic [BP-1:0]              b_r;
    logic [WS-1:0]              side_r;
    logic [AW-1:0]              acc_r;
    logic [AW-1:0]              acc_nxt;
    logic [WA+DIGIT_BITS-1:0]   pp;

    // accumulate one digit's partial product
    always_comb begin
      pp      = a_w[k] * b_w[k][k*DIGIT_BITS +: DIGIT_BITS];
      acc_nxt = acc_w[k] + (AW'(pp) << (k * DIGIT_BITS));
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r <= 1'b0;
      end else if (en) begin
        v_r <= v_w[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        a_r    <= a_w[k];
        b_r    <= b_w[k];
        side_r <= side_w[k];
        acc_r  <= acc_nxt;
      end
    end

    assign v_w[k+1]    = v_r;
    assign a_w[k+1]    = a_r;
    assign b_w[k+1]    = b_r;
    assign side_w[k+1] = side_r;
    assign acc_w[k+1]  = acc_r;
  end

  assign v_o    = v_w[NS];
  assign p_o    = acc_w[NS][WA+WB-1:0];
  assign side_o = side_w[NS];

endmodule

[sv/tsq_div_cell.sv]
// One restoring-division step: shift the remainder, try the divisor,
// append one quotient bit.
module tsq_div_cell import tsq_pkg::*; #(
  parameter int RW = 114,
  parameter int QW = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          v_i,
  input  logic [RW-1:0] rem_i,
  input  logic [RW-1:0] dvs_i,
  input  logic [QW-1:0] q_i,
  input  tsq_flags_t    f_i,
  output logic          v_o,
  output logic [RW-1:0] rem_o,
  output logic [RW-1:0] dvs_o,
  output logic [QW-1:0] q_o,
  output tsq_flags_t    f_o
);

  logic [RW:0]   r2;
  logic          ge;
  logic          v_r;
  logic [RW-1:0] rem_r, rem_nxt, dvs_r;
  logic [QW-1:0] q_r, q_nxt;
  tsq_flags_t    f_r;

  // trial subtract of the divisor
  always_comb begin
    r2      = {rem_i, 1'b0};
    ge      = (r2 >= {1'b0, dvs_i});
    rem_nxt = ge ? RW'(r2 - {1'b0, dvs_i}) : r2[RW-1:0];
    q_nxt   = {q_i[QW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_nxt;
      dvs_r <= dvs_i;
      q_r   <= q_nxt;
      f_r   <= f_i;
    end
  end

  assign v_o   = v_r;
  assign rem_o = rem_r;
  assign dvs_o = dvs_r;
  assign q_o   = q_r;
  assign f_o   = f_r;

endmodule

[sv/tsq_sqrt_cell.sv]
// One digit of the integer square root: bring down two radicand bits,
// try (root << 2) | 1, append one root bit.
module tsq_sqrt_cell import tsq_pkg::*; #(
  parameter int F = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           v_i,
  input  logic [2*F-1:0] x_i,
  input  logic [F+2:0]   rem_i,
  input  logic [F-1:0]   root_i,
  input  tsq_flags_t     f_i,
  output logic           v_o,
  output logic [2*F-1:0] x_o,
  output logic [F+2:0]   rem_o,
  output logic [F-1:0]   root_o,
  output tsq_flags_t     f_o
);

  logic [F+2:0]   rem4, trial, rem_nxt, rem_r;
  logic           ge;
  logic [F-1:0]   root_nxt, root_r;
  logic [2*F-1:0] x_r;
  logic           v_r;
  tsq_flags_t     f_r;

  always_comb begin
    rem4     = {rem_i[F:0], x_i[2*F-1 -: 2]};
    trial    = {1'b0, root_i, 2'b01};
    ge       = (rem4 >= trial);
    rem_nxt  = ge ? (rem4 - trial) : rem4;
    root_nxt = {root_i[F-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r    <= {x_i[2*F-3:0], 2'b00};
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
      f_r    <= f_i;
    end
  end

  assign v_o    = v_r;
  assign x_o    = x_r;
  assign rem_o  = rem_r;
  assign root_o = root_r;
  assign f_o    = f_r;

endmodule
